@@ rtl/stcc_pkg.sv @@
// stcc_pkg: shared types and constants of the segment tile congestion counter
// holds request kinds, register indexes, controller states and the command/status structs
// no dependencies
package stcc_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned CountFieldW = 16;
  localparam int unsigned TouchW      = 7;
  localparam int unsigned KindW       = 2;
  localparam int unsigned TileSelW    = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgUseW     = 7;
  localparam int unsigned ShrinkShift = 3;

  typedef enum logic [KindW-1:0] {
    KIND_ADD      = 2'd0,
    KIND_ADD_CRIT = 2'd1,
    KIND_READ     = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_LIMIT_X     = 3'd2,
    REG_LIMIT_Y     = 3'd3,
    REG_TILE_W      = 3'd4,
    REG_TILE_H      = 3'd5,
    REG_COLS_IN_USE = 3'd6,
    REG_ROWS_IN_USE = 3'd7
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLAMP,
    ST_TREAD,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_END_RD,
    ST_END_WR,
    ST_CHECK,
    ST_CUR_RD,
    ST_CUR_WR,
    ST_EDGE,
    ST_DIFF,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_ADD,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic clamp;
    logic div_start;
    logic div_store;
    logic mem_rd;
    logic mem_wr;
    logic sel_tile;
    logic sel_end;
    logic count_step;
    logic edge_mul;
    logic diff;
    logic mul_load;
    logic mul_step;
    logic mul_add;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  clear_last;
    kind_t kind;
    logic  div_busy;
    logic  div_last;
    logic  walk_more;
    logic  no_line_test;
    logic  mul_last;
    logic  prod_last;
  } status_t;

endpackage

@@ rtl/segment_tile_congestion_counter.sv @@
// segment_tile_congestion_counter: top level, per-tile wire and critical-wire counters
// depends on stcc_pkg, stcc_controller and stcc_datapath
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  kind start_x start_y end_x end_y tile_col tile_row
//   out      output     out_valid/out_stall  wire_count critical_count tiles_touched clamped
//   cfg      input      cfg_en               cfg_index cfg_data
//
// after reset a clearing pass zeroes the counters of all MAX_COLS*MAX_ROWS tiles, no requests taken
// a read or unknown request does no division and no walk; a segment runs four index
// divisions, then for each tile step one counter read-modify-write, and for a diagonal
// step also a serial 8-bit-digit line-side multiply
// one request at a time; a finished result waits in the output register while the
// next request is taken, a stalled output holds the block in its final state
module segment_tile_congestion_counter #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [stcc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [stcc_pkg::CoordW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stcc_pkg::KindW-1:0]       kind,
  input  logic [stcc_pkg::CoordW-1:0]      start_x,
  input  logic [stcc_pkg::CoordW-1:0]      start_y,
  input  logic [stcc_pkg::CoordW-1:0]      end_x,
  input  logic [stcc_pkg::CoordW-1:0]      end_y,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_col,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stcc_pkg::CountFieldW-1:0] wire_count,
  output logic [stcc_pkg::CountFieldW-1:0] critical_count,
  output logic [stcc_pkg::TouchW-1:0]      tiles_touched,
  output logic                            clamped
);
  import stcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  stcc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  stcc_datapath #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .tile_col       (tile_col),
    .tile_row       (tile_row),
    .cmd            (cmd),
    .status         (status),
    .wire_count     (wire_count),
    .critical_count (critical_count),
    .tiles_touched  (tiles_touched),
    .clamped        (clamped)
  );

endmodule

@@ rtl/stcc_divider.sv @@
// stcc_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on stcc_pkg for the coordinate width
module stcc_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [stcc_pkg::CoordW-1:0] dividend,
  input  logic [stcc_pkg::CoordW-1:0] divisor,
  output logic                       busy,
  output logic [stcc_pkg::CoordW-1:0] quotient
);
  import stcc_pkg::*;

  localparam int unsigned CntW = $clog2(CoordW);

  logic [CntW-1:0]   cnt;
  logic [CoordW-1:0] rem;
  logic [CoordW-1:0] dvs;
  logic [CoordW:0]   trial;

  assign trial = {rem, quotient[CoordW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(CoordW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= CoordW'(trial - {1'b0, dvs});
        quotient <= {quotient[CoordW-2:0], 1'b1};
      end else begin
        rem      <= trial[CoordW-1:0];
        quotient <= {quotient[CoordW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/stcc_datapath.sv @@
// stcc_datapath: configuration registers, clamp and tile index logic, walk position,
// serial line-side multiplier and the two tile counter memories
// depends on stcc_pkg and stcc_divider
module stcc_datapath #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [stcc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [stcc_pkg::CoordW-1:0]      cfg_data,
  input  logic [stcc_pkg::KindW-1:0]       kind,
  input  logic [stcc_pkg::CoordW-1:0]      start_x,
  input  logic [stcc_pkg::CoordW-1:0]      start_y,
  input  logic [stcc_pkg::CoordW-1:0]      end_x,
  input  logic [stcc_pkg::CoordW-1:0]      end_y,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_col,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_row,
  input  stcc_pkg::cmd_t                  cmd,
  output stcc_pkg::status_t               status,
  output logic [stcc_pkg::CountFieldW-1:0] wire_count,
  output logic [stcc_pkg::CountFieldW-1:0] critical_count,
  output logic [stcc_pkg::TouchW-1:0]      tiles_touched,
  output logic                            clamped
);
  import stcc_pkg::*;

  localparam int TILES = MAX_COLS * MAX_ROWS;
  localparam int AW    = TILES > 1 ? $clog2(TILES) : 1;
  localparam int CIW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int RIW   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int MAXN  = MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS;
  localparam int NW    = $clog2(MAXN + 1);
  localparam int SW    = $clog2(MAX_COLS + MAX_ROWS + 1);
  localparam int PW    = CoordW + NW;
  localparam int DW    = PW + 2;
  localparam int ND    = (DW + 7) / 8;
  localparam int BW    = ND * 8;
  localparam int PPW   = DW + 8;
  localparam int ACCW  = DW + BW;
  localparam int SUMW  = ACCW + 2;
  localparam int DGW   = ND > 1 ? $clog2(ND) : 1;

  // configuration
  logic [CoordW-1:0]  origin_x, origin_y, limit_x, limit_y, tile_w, tile_h;
  logic [CfgUseW-1:0] cols_in_use, rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      limit_x     <= '1;
      limit_y     <= '1;
      tile_w      <= CoordW'(1);
      tile_h      <= CoordW'(1);
      cols_in_use <= CfgUseW'(64);
      rows_in_use <= CfgUseW'(64);
    end else if (cfg_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Y:    origin_y    <= cfg_data;
        REG_LIMIT_X:     limit_x     <= cfg_data;
        REG_LIMIT_Y:     limit_y     <= cfg_data;
        REG_TILE_W:      tile_w      <= cfg_data;
        REG_TILE_H:      tile_h      <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data[CfgUseW-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[CfgUseW-1:0];
      endcase
    end
  end

  logic [NW-1:0]     cols_eff, rows_eff;
  logic [CoordW-1:0] tw_eff, th_eff;

  always_comb begin
    if (cols_in_use == '0) cols_eff = NW'(1);
    else if (32'(cols_in_use) > 32'(MAX_COLS)) cols_eff = NW'(MAX_COLS);
    else cols_eff = NW'(cols_in_use);
    if (rows_in_use == '0) rows_eff = NW'(1);
    else if (32'(rows_in_use) > 32'(MAX_ROWS)) rows_eff = NW'(MAX_ROWS);
    else rows_eff = NW'(rows_in_use);
  end

  assign tw_eff = tile_w == '0 ? CoordW'(1) : tile_w;
  assign th_eff = tile_h == '0 ? CoordW'(1) : tile_h;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v,
      input logic [CoordW-1:0] lo, input logic [CoordW-1:0] hi,
      input logic [CoordW-1:0] size);
    logic [CoordW-1:0] d;
    d = size >> ShrinkShift;
    if (v < lo) return lo;
    if (v > hi) return hi >= d ? hi - d : '0;
    return v;
  endfunction

  function automatic logic outside(input logic [CoordW-1:0] v,
      input logic [CoordW-1:0] lo, input logic [CoordW-1:0] hi);
    return (v < lo) || (v > hi);
  endfunction

  // request registers
  kind_t                kind_r;
  logic [CoordW-1:0]    sx, sy, ex, ey;
  logic [TileSelW-1:0]  tcol, trow;
  logic                 rd_ok;
  logic [CoordW-1:0]    csx, csy, cex, cey;
  logic                 flag;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= kind_t'(kind);
      sx     <= start_x;
      sy     <= start_y;
      ex     <= end_x;
      ey     <= end_y;
      tcol   <= tile_col;
      trow   <= tile_row;
      rd_ok  <= (32'(tile_col) < 32'(MAX_COLS)) && (32'(tile_row) < 32'(MAX_ROWS));
    end
    if (cmd.clamp) begin
      csx  <= clamp_coord(sx, origin_x, limit_x, tile_w);
      csy  <= clamp_coord(sy, origin_y, limit_y, tile_h);
      cex  <= clamp_coord(ex, origin_x, limit_x, tile_w);
      cey  <= clamp_coord(ey, origin_y, limit_y, tile_h);
      flag <= outside(sx, origin_x, limit_x) || outside(sy, origin_y, limit_y) ||
              outside(ex, origin_x, limit_x) || outside(ey, origin_y, limit_y);
    end
  end

  // tile index divisions
  logic [1:0]        div_sel;
  logic [CoordW-1:0] div_cs, div_org, div_size, dividend, divisor, quotient;
  logic              div_busy;
  logic [NW-1:0]     idx_lim, q_lim;

  always_comb begin
    unique case (div_sel)
      2'd0: begin div_cs = csx; div_org = origin_x; div_size = tile_w; end
      2'd1: begin div_cs = csy; div_org = origin_y; div_size = tile_h; end
      2'd2: begin div_cs = cex; div_org = origin_x; div_size = tile_w; end
      default: begin div_cs = cey; div_org = origin_y; div_size = tile_h; end
    endcase
  end

  assign dividend = div_cs >= div_org ? div_cs - div_org : '0;
  assign divisor  = div_size == '0 ? CoordW'(1) : div_size;
  assign idx_lim  = div_sel[0] ? rows_eff - 1'b1 : cols_eff - 1'b1;
  assign q_lim    = quotient > 32'(idx_lim) ? idx_lim : NW'(quotient);

  stcc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // walk position
  logic [CIW-1:0]   c, ec;
  logic [RIW-1:0]   r, er;
  logic [SW-1:0]    steps;
  logic [TouchW-1:0] touched;
  logic             right, up;

  assign right = c < ec;
  assign up    = r < er;

  // line side test
  logic [PW-1:0]    xe_prod, yc_prod;
  logic [NW-1:0]    mx, my;
  logic [DW-1:0]    a0, b0, a1, b1, a_sel, b_sel, am, bm;
  logic [BW-1:0]    bsh;
  logic [ACCW-1:0]  acc;
  logic [SUMW-1:0]  sum;
  logic [PPW-1:0]   pp;
  logic [DGW-1:0]   dig_cnt;
  logic             neg, prod_sel;
  logic             sum_zero, t_pos, move_row, move_col;

  assign mx    = NW'(c) + NW'(right);
  assign my    = NW'(r) + NW'(up);
  assign a_sel = prod_sel ? a1 : a0;
  assign b_sel = prod_sel ? b1 : b0;
  assign bm    = b_sel[DW-1] ? DW'(-b_sel) : b_sel;
  assign pp    = PPW'(am) * PPW'(bsh[BW-1 -: 8]);

  always_ff @(posedge clk) begin
    if (cmd.edge_mul) begin
      xe_prod <= PW'(tw_eff) * PW'(mx);
      yc_prod <= PW'(th_eff) * PW'(my);
    end
    if (cmd.diff) begin
      a0       <= DW'(sy) - DW'(origin_y) - DW'(yc_prod);
      b0       <= DW'(ex) - DW'(sx);
      a1       <= DW'(ey) - DW'(sy);
      b1       <= DW'(origin_x) + DW'(xe_prod) - DW'(sx);
      sum      <= '0;
      prod_sel <= 1'b0;
    end
    if (cmd.mul_load) begin
      neg     <= a_sel[DW-1] ^ b_sel[DW-1];
      am      <= a_sel[DW-1] ? DW'(-a_sel) : a_sel;
      bsh     <= BW'(bm);
      acc     <= '0;
      dig_cnt <= DGW'(ND - 1);
    end
    if (cmd.mul_step) begin
      acc     <= (acc << 8) + ACCW'(pp);
      bsh     <= bsh << 8;
      dig_cnt <= dig_cnt - 1'b1;
    end
    if (cmd.mul_add) begin
      sum      <= neg ? sum - SUMW'(acc) : sum + SUMW'(acc);
      prod_sel <= 1'b1;
    end
  end

  assign sum_zero = sum == '0;
  assign t_pos    = !sum_zero && (sum[SUMW-1] == (ex < sx));

  always_comb begin
    priority if (c == ec) begin
      move_row = 1'b1; move_col = 1'b0;
    end else if (r == er) begin
      move_row = 1'b0; move_col = 1'b1;
    end else if (sx == ex) begin
      move_row = 1'b1; move_col = 1'b0;
    end else if (sum_zero) begin
      move_row = 1'b1; move_col = 1'b1;
    end else if (up) begin
      move_row = t_pos; move_col = !t_pos;
    end else begin
      move_row = !t_pos; move_col = t_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      div_sel <= '0;
      touched <= TouchW'(1);
      steps   <= '0;
    end
    if (cmd.div_store) begin
      div_sel <= div_sel + 1'b1;
      unique case (div_sel)
        2'd0: c  <= CIW'(q_lim);
        2'd1: r  <= RIW'(q_lim);
        2'd2: ec <= CIW'(q_lim);
        default: er <= RIW'(q_lim);
      endcase
    end
    if (cmd.count_step) begin
      if (touched != '1) touched <= touched + 1'b1;
      steps <= steps + 1'b1;
    end
    if (cmd.step) begin
      if (move_row) r <= up ? r + 1'b1 : r - 1'b1;
      if (move_col) c <= right ? c + 1'b1 : c - 1'b1;
    end
  end

  // counter memories
  logic [COUNT_BITS-1:0] wire_mem [TILES];
  logic [COUNT_BITS-1:0] crit_mem [TILES];
  logic [COUNT_BITS-1:0] wire_rd, crit_rd, cur_val, wr_data;
  logic [AW-1:0]         clr_addr, mem_addr, tile_a, end_a, cur_a;
  logic                  wire_we, crit_we, is_crit;

  assign tile_a = AW'(AW'(trow) * AW'(MAX_COLS)) + AW'(tcol);
  assign end_a  = AW'(AW'(er) * AW'(MAX_COLS)) + AW'(ec);
  assign cur_a  = AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);

  always_comb begin
    priority if (cmd.clear) mem_addr = clr_addr;
    else if (cmd.sel_tile) mem_addr = tile_a;
    else if (cmd.sel_end) mem_addr = end_a;
    else mem_addr = cur_a;
  end

  assign is_crit = kind_r == KIND_ADD_CRIT;
  assign cur_val = is_crit ? crit_rd : wire_rd;
  assign wr_data = cmd.clear ? '0 : (cur_val != '1 ? cur_val + 1'b1 : cur_val);
  assign wire_we = cmd.clear || (cmd.mem_wr && !is_crit);
  assign crit_we = cmd.clear || (cmd.mem_wr && is_crit);

  always_ff @(posedge clk) begin
    if (wire_we) wire_mem[mem_addr] <= wr_data;
    if (cmd.mem_rd) wire_rd <= wire_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (crit_we) crit_mem[mem_addr] <= wr_data;
    if (cmd.mem_rd) crit_rd <= crit_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // result register
  logic is_add;
  assign is_add = (kind_r == KIND_ADD) || (kind_r == KIND_ADD_CRIT);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      wire_count     <= (kind_r == KIND_READ && rd_ok) ? CountFieldW'(wire_rd) : '0;
      critical_count <= (kind_r == KIND_READ && rd_ok) ? CountFieldW'(crit_rd) : '0;
      tiles_touched  <= is_add ? touched : '0;
      clamped        <= is_add ? flag : 1'b0;
    end
  end

  always_comb begin
    status.clear_last   = clr_addr == AW'(TILES - 1);
    status.kind         = kind_r;
    status.div_busy     = div_busy;
    status.div_last     = div_sel == 2'd3;
    status.walk_more    = ((c != ec) || (r != er)) &&
                          (steps < SW'(cols_eff) + SW'(rows_eff));
    status.no_line_test = (c == ec) || (r == er) || (sx == ex);
    status.mul_last     = dig_cnt == '0;
    status.prod_last    = prod_sel;
  end

endmodule

@@ rtl/stcc_controller.sv @@
// stcc_controller: sequencer for clearing, tile reads and segment walks
// depends on stcc_pkg; drives the datapath through cmd_t and reads status_t
module stcc_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  stcc_pkg::status_t status,
  output stcc_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import stcc_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        unique case (status.kind)
          KIND_READ:               state_next = ST_TREAD;
          KIND_NOP:                state_next = ST_DONE;
          KIND_ADD, KIND_ADD_CRIT: state_next = ST_DIV_LOAD;
        endcase
      end
      ST_TREAD: begin
        cmd.mem_rd   = 1'b1;
        cmd.sel_tile = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!status.div_busy) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        state_next    = status.div_last ? ST_END_RD : ST_DIV_LOAD;
      end
      ST_END_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.sel_end = 1'b1;
        state_next  = ST_END_WR;
      end
      ST_END_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.sel_end = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.walk_more ? ST_CUR_RD : ST_DONE;
      end
      ST_CUR_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_CUR_WR;
      end
      ST_CUR_WR: begin
        cmd.mem_wr     = 1'b1;
        cmd.count_step = 1'b1;
        state_next     = status.no_line_test ? ST_STEP : ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_mul = 1'b1;
        state_next   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL_LOAD;
      end
      ST_MUL_LOAD: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        cmd.mul_add = 1'b1;
        state_next  = status.prod_last ? ST_STEP : ST_MUL_LOAD;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ bench/segment_tile_congestion_checker.sv @@
// segment_tile_congestion_checker: watches the request, result and register channels,
// keeps its own tile counters and compares every result in order
// depends on stcc_pkg
`timescale 1ns / 100ps

module segment_tile_congestion_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [stcc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [stcc_pkg::CoordW-1:0]      cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [stcc_pkg::KindW-1:0]       kind,
  input  logic [stcc_pkg::CoordW-1:0]      start_x,
  input  logic [stcc_pkg::CoordW-1:0]      start_y,
  input  logic [stcc_pkg::CoordW-1:0]      end_x,
  input  logic [stcc_pkg::CoordW-1:0]      end_y,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_col,
  input  logic [stcc_pkg::TileSelW-1:0]    tile_row,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [stcc_pkg::CountFieldW-1:0] wire_count,
  input  logic [stcc_pkg::CountFieldW-1:0] critical_count,
  input  logic [stcc_pkg::TouchW-1:0]      tiles_touched,
  input  logic                             clamped,
  output int                               errors,
  output int                               pending
);
  import stcc_pkg::*;

  typedef struct {
    logic [15:0] wires;
    logic [15:0] crits;
    logic [6:0]  touched;
    logic        clamped;
  } tally_t;

  logic [31:0] org_x, org_y, lim_x, lim_y, size_w, size_h;
  logic [6:0]  use_cols, use_rows;
  logic [15:0] wire_tally [4096];
  logic [15:0] crit_tally [4096];
  tally_t      expected_q [$];

  function automatic logic [31:0] clamp_coord(input logic [31:0] v, lo, hi, size,
                                              inout bit flag);
    logic [31:0] shrink;
    shrink = size >> 3;
    if (v < lo) begin
      flag = 1;
      return lo;
    end
    if (v > hi) begin
      flag = 1;
      return hi >= shrink ? hi - shrink : 32'd0;
    end
    return v;
  endfunction

  function automatic logic [31:0] tile_of(input logic [31:0] v, org, size, count);
    logic [31:0] off, s, idx;
    off = v >= org ? v - org : 32'd0;
    s = size == 0 ? 32'd1 : size;
    idx = off / s;
    return idx > count - 1 ? count - 1 : idx;
  endfunction

  function automatic logic [31:0] eff_count(input logic [6:0] n);
    if (n == 0) return 1;
    return n > 64 ? 64 : n;
  endfunction

  // sign of the segment line against a tile corner, exact
  function automatic int line_side(input logic [31:0] x1, y1, x2, y2,
                                   input logic [63:0] xe, yc);
    logic signed [127:0] dx, p, q, s;
    int sg;
    dx = $signed({96'd0, x2}) - $signed({96'd0, x1});
    p = ($signed({96'd0, y1}) - $signed({64'd0, yc})) * dx;
    q = ($signed({96'd0, y2}) - $signed({96'd0, y1})) *
        ($signed({64'd0, xe}) - $signed({96'd0, x1}));
    s = p + q;
    sg = s == 0 ? 0 : (s < 0 ? -1 : 1);
    return dx < 0 ? -sg : sg;
  endfunction

  function automatic void bump(input bit crit, input logic [31:0] c, r);
    logic [11:0] i;
    i = {r[5:0], c[5:0]};
    if (crit) begin
      if (crit_tally[i] != 16'hFFFF) crit_tally[i] = crit_tally[i] + 1;
    end else begin
      if (wire_tally[i] != 16'hFFFF) wire_tally[i] = wire_tally[i] + 1;
    end
  endfunction

  function automatic tally_t tally_request(input logic [1:0] k,
                                           input logic [31:0] sx, sy, ex, ey,
                                           input logic [5:0] tc, tr);
    tally_t t;
    logic [31:0] cols, rows, c, r, ec, er, steps, touched;
    logic [63:0] tw, th, xe, yc;
    bit flag, crit, right, up, mrow, mcol;
    int side;
    t = '{default: '0};
    flag = 0;
    if (kind_t'(k) == KIND_READ) begin
      t.wires = wire_tally[{tr, tc}];
      t.crits = crit_tally[{tr, tc}];
      return t;
    end
    if (kind_t'(k) == KIND_NOP) return t;
    crit = kind_t'(k) == KIND_ADD_CRIT;
    cols = eff_count(use_cols);
    rows = eff_count(use_rows);
    tw = size_w == 0 ? 64'd1 : {32'd0, size_w};
    th = size_h == 0 ? 64'd1 : {32'd0, size_h};
    c  = tile_of(clamp_coord(sx, org_x, lim_x, size_w, flag), org_x, size_w, cols);
    r  = tile_of(clamp_coord(sy, org_y, lim_y, size_h, flag), org_y, size_h, rows);
    ec = tile_of(clamp_coord(ex, org_x, lim_x, size_w, flag), org_x, size_w, cols);
    er = tile_of(clamp_coord(ey, org_y, lim_y, size_h, flag), org_y, size_h, rows);
    touched = 1;
    steps = 0;
    bump(crit, ec, er);
    while ((c != ec || r != er) && steps < cols + rows) begin
      bump(crit, c, r);
      touched++;
      steps++;
      if (c == ec) begin
        r = r < er ? r + 1 : r - 1;
      end else if (r == er) begin
        c = c < ec ? c + 1 : c - 1;
      end else begin
        right = c < ec;
        up = r < er;
        xe = {32'd0, org_x} + tw * {32'd0, right ? c + 1 : c};
        yc = {32'd0, org_y} + th * {32'd0, up ? r + 1 : r};
        if (sx == ex) begin
          mrow = 1;
          mcol = 0;
        end else begin
          side = line_side(sx, sy, ex, ey, xe, yc);
          if (side == 0) begin
            mrow = 1;
            mcol = 1;
          end else begin
            mrow = up ? side > 0 : side < 0;
            mcol = !mrow;
          end
        end
        if (mrow) r = up ? r + 1 : r - 1;
        if (mcol) c = right ? c + 1 : c - 1;
      end
    end
    t.touched = touched > 127 ? 7'd127 : touched[6:0];
    t.clamped = flag;
    return t;
  endfunction

  always @(posedge clk) begin
    tally_t want;
    if (rst) begin
      org_x = 0; org_y = 0; lim_x = '1; lim_y = '1;
      size_w = 1; size_h = 1; use_cols = 64; use_rows = 64;
      foreach (wire_tally[i]) begin
        wire_tally[i] = 0;
        crit_tally[i] = 0;
      end
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result at %0t", $time);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.wires !== wire_count || want.crits !== critical_count ||
              want.touched !== tiles_touched || want.clamped !== clamped) begin
            if (errors < 10)
              $display({"result mismatch at %0t: exp w=%0d c=%0d t=%0d cl=%0d",
                        " got w=%0d c=%0d t=%0d cl=%0d"},
                       $time, want.wires, want.crits, want.touched, want.clamped,
                       wire_count, critical_count, tiles_touched, clamped);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          tally_request(kind, start_x, start_y, end_x, end_y,
                                        tile_col, tile_row));
      if (cfg_en) begin
        case (reg_index_t'(cfg_index))
          REG_ORIGIN_X:    org_x = cfg_data;
          REG_ORIGIN_Y:    org_y = cfg_data;
          REG_LIMIT_X:     lim_x = cfg_data;
          REG_LIMIT_Y:     lim_y = cfg_data;
          REG_TILE_W:      size_w = cfg_data;
          REG_TILE_H:      size_h = cfg_data;
          REG_COLS_IN_USE: use_cols = cfg_data[6:0];
          REG_ROWS_IN_USE: use_rows = cfg_data[6:0];
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

@@ bench/segment_tile_congestion_counter_test.sv @@
// segment_tile_congestion_counter_test: drives segment and read requests over several grid
// settings with random idling on both channels and gives the verdict
// depends on stcc_pkg, segment_tile_congestion_counter and segment_tile_congestion_checker
`timescale 1ns / 100ps

module segment_tile_congestion_counter_test;
  import stcc_pkg::*;

  localparam int CycleLimit = 25_000_000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_en = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  kind = 0;
  logic [31:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic [5:0]  tile_col = 0, tile_row = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] wire_count, critical_count;
  logic [6:0]  tiles_touched;
  logic        clamped;
  int          errors, pending;
  bit          calm = 0;
  int          stall_left = 0;
  int          cycles = 0;
  logic [31:0] ox, oy, lx, ly, tw, th;
  logic [6:0]  cols, rows;

  segment_tile_congestion_counter u_dut (.*);

  segment_tile_congestion_checker u_checker (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 0;
    end
  end

  task automatic put_request(input kind_t k, input logic [31:0] sx, sy, ex, ey,
                             input logic [5:0] tc, tr);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    tile_col <= tc; tile_row <= tr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t i, input logic [31:0] v);
    cfg_en <= 1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_en <= 0;
  endtask

  task automatic set_grid(input logic [31:0] ax, ay, bx, by, sw, sh,
                          input logic [6:0] nc, nr);
    ox = ax; oy = ay; lx = bx; ly = by; tw = sw; th = sh; cols = nc; rows = nr;
    write_reg(REG_ORIGIN_X, ax);
    write_reg(REG_ORIGIN_Y, ay);
    write_reg(REG_LIMIT_X, bx);
    write_reg(REG_LIMIT_Y, by);
    write_reg(REG_TILE_W, sw);
    write_reg(REG_TILE_H, sh);
    write_reg(REG_COLS_IN_USE, {25'd0, nc});
    write_reg(REG_ROWS_IN_USE, {25'd0, nr});
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] org, lim);
    logic [63:0] span;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom;
    if (sel == 1) return org - $urandom_range(1, 50);
    if (sel == 2) return lim + $urandom_range(1, 50);
    span = lim >= org ? {32'd0, lim - org} + 1 : 64'd1;
    return org + 32'({$urandom, $urandom} % span);
  endfunction

  task automatic random_request;
    int pick;
    kind_t k;
    logic [5:0] tc, tr;
    pick = $urandom_range(0, 99);
    k = pick < 40 ? KIND_ADD : pick < 70 ? KIND_ADD_CRIT : pick < 95 ? KIND_READ : KIND_NOP;
    tc = $urandom_range(0, 4) == 0 ? 6'($urandom) : 6'($urandom_range(0, cols - 1));
    tr = $urandom_range(0, 4) == 0 ? 6'($urandom) : 6'($urandom_range(0, rows - 1));
    put_request(k, pick_coord(ox, lx), pick_coord(oy, ly), pick_coord(ox, lx),
                pick_coord(oy, ly), tc, tr);
  endtask

  task automatic random_phase(input int n, input logic [6:0] max_use);
    logic [6:0] nc, nr;
    logic [31:0] sw, sh, ax, ay;
    logic [63:0] bx, by;
    nc = $urandom_range(1, max_use);
    nr = $urandom_range(1, max_use);
    sw = (32'd1 << $urandom_range(0, 22)) + $urandom_range(0, 7);
    sh = (32'd1 << $urandom_range(0, 22)) + $urandom_range(0, 7);
    ax = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20);
    ay = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20);
    bx = {32'd0, ax} + {32'd0, sw} * nc - 1 + $urandom_range(0, 3);
    by = {32'd0, ay} + {32'd0, sh} * nr - 1 + $urandom_range(0, 3);
    set_grid(ax, ay, bx > 64'hFFFF_FFFF ? '1 : bx[31:0], by > 64'hFFFF_FFFF ? '1 : by[31:0],
             sw, sh, nc, nr);
    repeat (n) random_request();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;

    // small grid with known geometry
    set_grid(1000, 2000, 1512, 2192, 64, 32, 8, 6);
    put_request(KIND_ADD, 1000, 2000, 1400, 2000, 0, 0);
    put_request(KIND_ADD, 1100, 2000, 1100, 2180, 0, 0);
    put_request(KIND_ADD, 1000, 2000, 1192, 2096, 0, 0);
    put_request(KIND_ADD_CRIT, 1500, 2010, 1003, 2190, 0, 0);
    put_request(KIND_ADD, 1192, 2096, 1000, 2000, 0, 0);
    put_request(KIND_ADD, 5, 7, 1300, 2100, 0, 0);
    put_request(KIND_ADD_CRIT, 1200, 2100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    put_request(KIND_ADD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    put_request(KIND_ADD, 1250, 2050, 1250, 2050, 0, 0);
    put_request(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 6'h3F, 6'h3F);
    put_request(KIND_READ, 0, 0, 0, 0, 0, 0);
    put_request(KIND_READ, 0, 0, 0, 0, 3, 1);
    put_request(KIND_READ, 0, 0, 0, 0, 7, 5);
    put_request(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                6'h3F, 6'h3F);
    drain();

    // full size grid, longest walks
    set_grid(0, 0, 128, 128, 2, 2, 64, 64);
    put_request(KIND_ADD, 0, 1, 127, 126, 0, 0);
    put_request(KIND_ADD_CRIT, 127, 0, 0, 127, 0, 0);
    put_request(KIND_ADD, 0, 0, 127, 127, 0, 0);
    put_request(KIND_READ, 0, 0, 0, 0, 0, 0);
    put_request(KIND_READ, 0, 0, 0, 0, 63, 0);
    drain();

    // register extremes
    set_grid('1, 0, 0, '1, '1, 1, 1, 64);
    repeat (15) random_request();
    drain();

    random_phase(40, 64);
    repeat (7) random_phase(200, 12);
    calm = 1;
    random_phase(200, 12);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/stcc_pkg.sv
rtl/stcc_divider.sv
rtl/stcc_datapath.sv
rtl/stcc_controller.sv
rtl/segment_tile_congestion_counter.sv
bench/segment_tile_congestion_checker.sv
bench/segment_tile_congestion_counter_test.sv
